// ----- hw/rtl/gjc_pkg.sv -----
// Shared types and constants for the grid junction counter.
// No dependencies; every other file of the block but gjc_line_store imports this package.
`timescale 1ns / 1ps

package gjc_pkg;

   // Default line store depth, the widest row the block can hold.
   localparam int MAX_WIDTH_DEF = 128;

   // Row width register.
   localparam int CSR_W = 8;
   localparam logic [CSR_W-1:0] ROW_WIDTH_RST = 8'd100;

   // Junction tallies saturate at their top value.
   localparam int TALLY_W = 15;
   localparam logic [TALLY_W-1:0] TALLY_MAX = 15'h7FFF;

   // One push of a pixel as it leaves the address stage.
   typedef struct packed {
      logic valid;       // a pixel (real or padding) is in this stage
      logic upper_rows;  // at least one full row came before this one
      logic has_left;    // column is not the first of the row
      logic has_right;   // column is not the last of the row
      logic pixel;       // the new pixel, which lies below the classed one
   } gjc_push_type;

   // Neighborhood of the classed pixel as read from the line stores.
   typedef struct packed {
      logic up;
      logic left;
      logic centre;
      logic right;
   } gjc_nbr_type;

endpackage

// ----- hw/rtl/gjc_line_store.sv -----
// Two line stores (row two back and row one back) with registered reads.
// Holds the write forwarding for reads that meet a write in the same cycle.
// Depends on gjc_pkg only through the top level's parameters.
`timescale 1ns / 1ps

module gjc_line_store #(
   parameter int MAX_WIDTH = 128,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic          clock,
   input  logic          reset,
   // Read side: classed column, its left and right neighbor columns.
   input  logic          rd_en,
   input  logic [AW-1:0] rd_col,
   input  logic [AW-1:0] rd_left_col,
   input  logic [AW-1:0] rd_right_col,
   output logic          up_bit,
   output logic          left_bit,
   output logic          centre_bit,
   output logic          right_bit,
   // Write side: one column of both lines per cycle.
   input  logic          wr_en,
   input  logic [AW-1:0] wr_col,
   input  logic          wr_above,
   input  logic          wr_centre
);

   logic above_mem  [MAX_WIDTH];
   logic centre_mem [MAX_WIDTH];

   logic q_up_ff, q_left_ff, q_centre_ff, q_right_ff;
   logic fw_up_ff, fw_left_ff, fw_centre_ff, fw_right_ff;
   logic fw_up_in, fw_left_in, fw_centre_in, fw_right_in;
   logic fw_above_ff, fw_cdata_ff;

   // A read that hits the column written in the same cycle takes the new data.
   always_comb begin
      fw_up_in     = wr_en && (wr_col == rd_col);
      fw_left_in   = wr_en && (wr_col == rd_left_col);
      fw_centre_in = wr_en && (wr_col == rd_col);
      fw_right_in  = wr_en && (wr_col == rd_right_col);
   end

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         above_mem[wr_col]  <= wr_above;
         centre_mem[wr_col] <= wr_centre;
      end
   end

   // Memory read ports, two per array, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_up_ff     <= above_mem[rd_col];
         q_left_ff   <= above_mem[rd_left_col];
         q_centre_ff <= centre_mem[rd_col];
         q_right_ff  <= centre_mem[rd_right_col];
         fw_above_ff <= wr_above;
         fw_cdata_ff <= wr_centre;
      end
   end

   // Forwarding flags are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_up_ff     <= 1'b0;
         fw_left_ff   <= 1'b0;
         fw_centre_ff <= 1'b0;
         fw_right_ff  <= 1'b0;
      end else if (rd_en) begin
         fw_up_ff     <= fw_up_in;
         fw_left_ff   <= fw_left_in;
         fw_centre_ff <= fw_centre_in;
         fw_right_ff  <= fw_right_in;
      end
   end

   assign up_bit     = fw_up_ff     ? fw_above_ff : q_up_ff;
   assign left_bit   = fw_left_ff   ? fw_above_ff : q_left_ff;
   assign centre_bit = fw_centre_ff ? fw_cdata_ff : q_centre_ff;
   assign right_bit  = fw_right_ff  ? fw_cdata_ff : q_right_ff;

endmodule

// ----- hw/rtl/gjc_tally.sv -----
// Junction classifier and the four saturating per-frame tallies.
// Depends on gjc_pkg for the push and neighborhood types.
`timescale 1ns / 1ps

module gjc_tally (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  gjc_pkg::gjc_push_type            push,
   input  gjc_pkg::gjc_nbr_type             nbr,
   output logic [gjc_pkg::TALLY_W-1:0]      cross_tally,
   output logic [gjc_pkg::TALLY_W-1:0]      tee_tally,
   output logic [gjc_pkg::TALLY_W-1:0]      turn_tally,
   output logic [gjc_pkg::TALLY_W-1:0]      end_tally
);
   import gjc_pkg::*;

   logic [TALLY_W-1:0] cross_ff, tee_ff, turn_ff, endc_ff;
   logic [TALLY_W-1:0] cross_in, tee_in, turn_in, endc_in;
   logic               n_up, n_left, n_right, n_down;
   logic [2:0]         n_count;
   logic               classed;

   // Neighbors outside the row read as clear.
   always_comb begin
      n_up    = nbr.up;
      n_left  = nbr.left & push.has_left;
      n_right = nbr.right & push.has_right;
      n_down  = push.pixel;
      n_count = 3'(n_up) + 3'(n_left) + 3'(n_right) + 3'(n_down);
      classed = push.valid && push.upper_rows && nbr.centre;
   end

   // Bump the matching tally, holding at the top value.
   always_comb begin
      cross_in = cross_ff;
      tee_in   = tee_ff;
      turn_in  = turn_ff;
      endc_in  = endc_ff;
      if (clear) begin
         cross_in = '0;
         tee_in   = '0;
         turn_in  = '0;
         endc_in  = '0;
      end else if (classed) begin
         case (n_count)
            3'd4: begin
               if (cross_ff != TALLY_MAX) cross_in = cross_ff + 1'b1;
            end
            3'd3: begin
               if (tee_ff != TALLY_MAX) tee_in = tee_ff + 1'b1;
            end
            3'd2: begin
               // A straight run has both neighbors on one axis.
               if ((n_left | n_right) && (n_up | n_down) && (turn_ff != TALLY_MAX)) begin
                  turn_in = turn_ff + 1'b1;
               end
            end
            3'd1: begin
               if (endc_ff != TALLY_MAX) endc_in = endc_ff + 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_ff <= '0;
         tee_ff   <= '0;
         turn_ff  <= '0;
         endc_ff  <= '0;
      end else begin
         cross_ff <= cross_in;
         tee_ff   <= tee_in;
         turn_ff  <= turn_in;
         endc_ff  <= endc_in;
      end
   end

   assign cross_tally = cross_ff;
   assign tee_tally   = tee_ff;
   assign turn_tally  = turn_ff;
   assign end_tally   = endc_ff;

endmodule

// ----- hw/rtl/grid_junction_counter.sv -----
// Top level of the grid junction counter: sequencer, address stage, result register.
// Depends on gjc_pkg, gjc_line_store and gjc_tally.
`timescale 1ns / 1ps

// Pixels stream in raster order at one per cycle while the block is in its
// run state; each pixel is written into the two line stores and the pixel
// above it is classed in the next cycle, so a row of any width runs at full
// rate. The transfer that carries frame_end starts the frame tail: the block
// stops taking pixels while it pads the current row with clear pixels (unless
// the final pixel ended its row) and then pushes one full clear row, followed
// by the last tally update. The result then waits in the output register, and
// once it is loaded both line stores are cleared one column per cycle before
// the next frame is taken. The same clearing pass runs after reset. The row
// width register may be written at any time the block is idle; 0 is taken as
// 1 and values above MAX_WIDTH as MAX_WIDTH.
module grid_junction_counter #(
   parameter int MAX_WIDTH = gjc_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Pixel channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_pixel_set,
   input  logic                          req_frame_end,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gjc_pkg::TALLY_W-1:0]   rsp_cross_count,
   output logic [gjc_pkg::TALLY_W-1:0]   rsp_tee_count,
   output logic [gjc_pkg::TALLY_W-1:0]   rsp_turn_count,
   output logic [gjc_pkg::TALLY_W-1:0]   rsp_end_count,
   // Row width register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gjc_pkg::CSR_W-1:0]     csr_row_width
);
   import gjc_pkg::*;

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int CW = (WW > CSR_W) ? WW : CSR_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_TAIL  = 3'd2;
   localparam logic [2:0] ST_DONE  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [CSR_W-1:0]   row_width_ff;
   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      col_ff, col_in;
   logic [1:0]         first_ff, first_in;
   logic               two_left_ff, two_left_in;
   logic [AW-1:0]      clr_ff, clr_in;
   gjc_push_type       s1_ff, s1_in;
   logic [AW-1:0]      s1_col_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TALLY_W-1:0] rsp_cross_ff, rsp_tee_ff, rsp_turn_ff, rsp_end_ff;

   logic [CW-1:0]      rw_ext, w_ext;
   logic [WW-1:0]      eff_w;
   logic [AW-1:0]      last_col, cur_col, left_col, right_col;
   logic               row_end, has_left, has_right;
   logic               req_fire, push_go, push_bit, rsp_load, tally_clear;
   logic               wr_en, wr_above, wr_centre;
   logic [AW-1:0]      wr_col;
   gjc_nbr_type        nbr;
   logic [TALLY_W-1:0] cross_tally, tee_tally, turn_tally, end_tally;

   // Row width register; always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RST;
      end else if (csr_valid) begin
         row_width_ff <= csr_row_width;
      end
   end

   // Row width in use, clamped to 1..MAX_WIDTH.
   always_comb begin
      rw_ext = CW'(row_width_ff);
      if (rw_ext == '0) begin
         w_ext = CW'(1);
      end else if (rw_ext > CW'(MAX_WIDTH)) begin
         w_ext = CW'(MAX_WIDTH);
      end else begin
         w_ext = rw_ext;
      end
      eff_w    = WW'(w_ext);
      last_col = AW'(eff_w - WW'(1));
   end

   // Address stage: a column past the row's end is taken as its last column.
   always_comb begin
      cur_col   = (WW'(col_ff) >= eff_w) ? last_col : col_ff;
      row_end   = (cur_col == last_col);
      has_left  = (cur_col != '0);
      has_right = !row_end;
      left_col  = has_left ? AW'(cur_col - 1'b1) : '0;
      right_col = has_right ? AW'(cur_col + 1'b1) : '0;
   end

   assign req_ready = (state_ff == ST_RUN);
   assign req_fire  = req_valid && req_ready;
   assign push_go   = req_fire || (state_ff == ST_TAIL);
   assign push_bit  = (state_ff == ST_RUN) ? req_pixel_set : 1'b0;

   // Sequencer and stream position.
   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      first_in    = first_ff;
      two_left_in = two_left_ff;
      clr_in      = clr_ff;
      rsp_load    = 1'b0;
      tally_clear = 1'b0;

      if (push_go) begin
         col_in = row_end ? '0 : AW'(cur_col + 1'b1);
         if (row_end && (first_ff != 2'd2)) begin
            first_in = first_ff + 1'b1;
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(MAX_WIDTH - 1)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            // A partial last row needs one more row end before the clear row.
            if (req_fire && req_frame_end) begin
               state_in    = ST_TAIL;
               two_left_in = !row_end;
            end
         end
         ST_TAIL: begin
            if (row_end) begin
               if (two_left_ff) begin
                  two_left_in = 1'b0;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load    = 1'b1;
               tally_clear = 1'b1;
               col_in      = '0;
               first_in    = 2'd0;
               clr_in      = '0;
               state_in    = ST_CLEAR;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         col_ff      <= '0;
         first_ff    <= 2'd0;
         two_left_ff <= 1'b0;
         clr_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         col_ff      <= col_in;
         first_ff    <= first_in;
         two_left_ff <= two_left_in;
         clr_ff      <= clr_in;
      end
   end

   // Classify stage register.
   always_comb begin
      s1_in.valid      = push_go;
      s1_in.upper_rows = (first_ff != 2'd0);
      s1_in.has_left   = has_left;
      s1_in.has_right  = has_right;
      s1_in.pixel      = push_bit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         s1_col_ff <= cur_col;
      end
   end

   // Write back: the old centre moves up, the new pixel becomes the centre.
   // The clearing pass uses the same port while no push is in flight.
   always_comb begin
      wr_en     = s1_ff.valid || (state_ff == ST_CLEAR);
      wr_col    = (state_ff == ST_CLEAR) ? clr_ff : s1_col_ff;
      wr_above  = s1_ff.valid && s1_ff.upper_rows && nbr.centre;
      wr_centre = s1_ff.valid && s1_ff.pixel;
   end

   gjc_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_store (
      .clock        (clock),
      .reset        (reset),
      .rd_en        (push_go),
      .rd_col       (cur_col),
      .rd_left_col  (left_col),
      .rd_right_col (right_col),
      .up_bit       (nbr.up),
      .left_bit     (nbr.left),
      .centre_bit   (nbr.centre),
      .right_bit    (nbr.right),
      .wr_en        (wr_en),
      .wr_col       (wr_col),
      .wr_above     (wr_above),
      .wr_centre    (wr_centre)
   );

   gjc_tally u_tally (
      .clock       (clock),
      .reset       (reset),
      .clear       (tally_clear),
      .push        (s1_ff),
      .nbr         (nbr),
      .cross_tally (cross_tally),
      .tee_tally   (tee_tally),
      .turn_tally  (turn_tally),
      .end_tally   (end_tally)
   );

   // Result register; a loaded result waits here while the next frame starts.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_cross_ff <= cross_tally;
         rsp_tee_ff   <= tee_tally;
         rsp_turn_ff  <= turn_tally;
         rsp_end_ff   <= end_tally;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cross_count = rsp_cross_ff;
   assign rsp_tee_count   = rsp_tee_ff;
   assign rsp_turn_count  = rsp_turn_ff;
   assign rsp_end_count   = rsp_end_ff;

`ifndef SYNTH
   // The clearing pass never shares the write port with a push.
   a_clear_no_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !s1_ff.valid)
      else $error("push in flight during line store clearing");

   // The final pixel starts the frame tail.
   a_tail_start: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_frame_end) |=> (state_ff == ST_TAIL))
      else $error("frame end did not start the tail");

   // The tail ends on the last row end and moves to the done state.
   a_tail_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_TAIL) && row_end && !two_left_ff) |=> (state_ff == ST_DONE))
      else $error("tail did not end on its last row");

   // Loading a result clears the tallies and starts the clearing pass.
   a_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> ((state_ff == ST_CLEAR) && rsp_valid_ff && (cross_tally == '0)
                    && (end_tally == '0) && (col_ff == '0)))
      else $error("result load did not restart the frame");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for grid_junction_counter: streams raster pixel frames and
// checks every tally result against a built-in junction predictor.
// Depends on gjc_pkg and the grid_junction_counter RTL.
`timescale 1ns / 1ps

module tb_top;
   import gjc_pkg::*;

   localparam int LINE_DEPTH  = MAX_WIDTH_DEF;
   // Frame tail plus the line-store clearing pass, with some slack.
   localparam int TAIL_CYCLES = 3 * LINE_DEPTH + 16;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 400;

   // Tallies of one frame as they leave the block.
   typedef struct packed {
      logic [TALLY_W-1:0] crosses;
      logic [TALLY_W-1:0] tees;
      logic [TALLY_W-1:0] turns;
      logic [TALLY_W-1:0] ends;
   } tally_set_type;

   // Junction predictor and store of expected frame tallies.
   class junction_scoreboard;
      logic [CSR_W-1:0]   width_reg;
      bit                 above_row [LINE_DEPTH];
      bit                 centre_row[LINE_DEPTH];
      int unsigned        column;
      int unsigned        rows_primed;
      logic [TALLY_W-1:0] cross_t, tee_t, turn_t, end_t;
      tally_set_type      due_q[$];
      int unsigned        pixels_seen;
      int unsigned        frames_checked;
      int unsigned        errors;

      function new();
         width_reg = ROW_WIDTH_RST;
         pixels_seen = 0;
         frames_checked = 0;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         foreach (above_row[i]) begin
            above_row[i] = 1'b0;
            centre_row[i] = 1'b0;
         end
         column = 0;
         rows_primed = 0;
         cross_t = '0;
         tee_t = '0;
         turn_t = '0;
         end_t = '0;
      endfunction

      // Zero acts as one and anything past the line stores as their depth.
      function int unsigned used_width();
         if (width_reg == 0) return 1;
         if (width_reg > LINE_DEPTH) return LINE_DEPTH;
         return width_reg;
      endfunction

      function logic [TALLY_W-1:0] sat_inc(logic [TALLY_W-1:0] t);
         return (t < TALLY_MAX) ? t + 1'b1 : t;
      endfunction

      function void classify(bit up, bit left, bit right, bit down);
         int n;
         n = int'(up) + int'(left) + int'(right) + int'(down);
         if (n == 4) cross_t = sat_inc(cross_t);
         else if (n == 3) tee_t = sat_inc(tee_t);
         else if (n == 2) begin
            // Straight runs have both neighbors on one axis and are skipped.
            if ((left | right) && (up | down)) turn_t = sat_inc(turn_t);
         end
         else if (n == 1) end_t = sat_inc(end_t);
      endfunction

      // One pixel enters the window; the centre-row pixel above it is classed.
      function void shift_in(bit pix);
         int unsigned w, c;
         w = used_width();
         c = (column >= w) ? w - 1 : column;
         if (rows_primed == 0) begin
            above_row[c] = 1'b0;
         end else begin
            if (centre_row[c])
               classify(above_row[c], (c > 0) ? above_row[c - 1] : 1'b0,
                        (c + 1 < w) ? centre_row[c + 1] : 1'b0, pix);
            above_row[c] = centre_row[c];
         end
         centre_row[c] = pix;
         if (c + 1 >= w) begin
            column = 0;
            if (rows_primed < 2) rows_primed++;
         end else begin
            column = c + 1;
         end
      endfunction

      // Called for every accepted pixel transfer.
      function void note_pixel(bit pix, bit fend);
         int unsigned w;
         tally_set_type due;
         pixels_seen++;
         shift_in(pix);
         if (!fend) return;
         // Pad the open row, then flush one clear row below the frame.
         while (column != 0) shift_in(1'b0);
         w = used_width();
         repeat (w) shift_in(1'b0);
         due = '{crosses: cross_t, tees: tee_t, turns: turn_t, ends: end_t};
         due_q.push_back(due);
         clear_frame();
      endfunction

      function void compare_field(string name, logic [TALLY_W-1:0] want,
                                  logic [TALLY_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      // Called for every accepted result transfer.
      function void check_result(tally_set_type got);
         tally_set_type want;
         if (due_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d/%0d",
                     $time, got.crosses, got.tees, got.turns, got.ends);
            return;
         end
         want = due_q.pop_front();
         frames_checked++;
         compare_field("cross_count", want.crosses, got.crosses);
         compare_field("tee_count", want.tees, got.tees);
         compare_field("turn_count", want.turns, got.turns);
         compare_field("end_count", want.ends, got.ends);
      endfunction

      function int unsigned pending();
         return due_q.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_pixel_set;
   logic                 req_frame_end;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [TALLY_W-1:0]   rsp_cross_count;
   logic [TALLY_W-1:0]   rsp_tee_count;
   logic [TALLY_W-1:0]   rsp_turn_count;
   logic [TALLY_W-1:0]   rsp_end_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_W-1:0]     csr_row_width;

   junction_scoreboard sb = new();
   int gap_pct;
   int stall_pct;
   int unsigned cycle_count = 0;
   int gap_mix[4]   = '{0, 57, 0, 22};
   int stall_mix[4] = '{0, 0, 57, 22};

   grid_junction_counter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_set   (req_pixel_set),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_cross_count (rsp_cross_count),
      .rsp_tee_count   (rsp_tee_count),
      .rsp_turn_count  (rsp_turn_count),
      .rsp_end_count   (rsp_end_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_row_width   (csr_row_width)
   );

   // 10 ns clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run guard: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   // Monitor: every completed transfer goes to the scoreboard.
   always @(posedge clock) begin
      tally_set_type got;
      if (!reset) begin
         if (csr_valid && csr_ready) sb.width_reg = csr_row_width;
         if (req_valid && req_ready) sb.note_pixel(req_pixel_set, req_frame_end);
         if (rsp_valid && rsp_ready) begin
            got = '{crosses: rsp_cross_count, tees: rsp_tee_count,
                    turns: rsp_turn_count, ends: rsp_end_count};
            sb.check_result(got);
         end
      end
   end

   // Result receiver stalls at the rate of the current phase.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Drive one pixel, with an optional idle gap first, and wait for its transfer.
   task automatic send_pixel(input bit pix, input bit fend);
      int gap;
      gap = 0;
      if ($urandom_range(99) < gap_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_set <= pix;
      req_frame_end <= fend;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Send count bits of a pattern, leftmost first, closing the frame on the last.
   task automatic send_bits(input logic [31:0] pattern, input int count);
      for (int i = count - 1; i >= 0; i--) send_pixel(pattern[i], i == 0);
   endtask

   // Hold the sender until every expected result has come and the block is quiet.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_width(input logic [CSR_W-1:0] value);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_row_width <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly narrow rows; a few zero, full-depth and beyond-depth settings.
   function automatic logic [CSR_W-1:0] pick_width();
      int r;
      r = $urandom_range(99);
      if (r < 65) return CSR_W'($urandom_range(1, 8));
      if (r < 85) return CSR_W'($urandom_range(9, 40));
      if (r < 90) return '0;
      if (r < 95) return CSR_W'(LINE_DEPTH);
      return CSR_W'($urandom_range(LINE_DEPTH + 1, 255));
   endfunction

   // One frame of whole rows at a random density; some frames stop early.
   task automatic random_frame();
      int unsigned w, rows, n, dens;
      int levels[4] = '{20, 50, 75, 95};
      w = sb.used_width();
      rows = (w > 40) ? $urandom_range(1, 3) : $urandom_range(1, 8);
      n = w * rows;
      if ($urandom_range(99) < 15) n = $urandom_range(1, n);
      dens = levels[$urandom_range(3)];
      for (int unsigned k = 0; k < n; k++)
         send_pixel($urandom_range(99) < dens, k == n - 1);
   endtask

   initial begin
      int unsigned goal, part;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_set = 1'b0;
      req_frame_end = 1'b0;
      csr_valid = 1'b0;
      csr_row_width = '0;
      gap_pct = 0;
      stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames. A lone pixel closing a frame at the reset width.
      send_pixel(1'b1, 1'b1);
      write_width(8'd3);
      send_bits(32'b010_111_010, 9);   // one cross and four ends
      send_bits(32'b111_010, 6);       // a tee over a stub
      send_bits(32'b110_10, 5);        // a turn; the frame stops mid-row
      send_bits(32'b111, 3);           // a straight run is no turn
      // Narrow the row while a frame is open, past the current column.
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b0);
      write_width(8'd1);
      send_bits(32'b11, 2);
      write_width(8'd0);
      send_bits(32'b1110, 4);
      write_width(8'd255);
      send_bits(32'b10110, 5);
      // Fully set frame of two rows at full depth.
      write_width(CSR_W'(LINE_DEPTH));
      for (int k = 0; k < LINE_DEPTH * 2; k++)
         send_pixel(1'b1, k == LINE_DEPTH * 2 - 1);

      // Random frames under four sender and receiver mixes.
      for (int p = 0; p < 4; p++) begin
         wait_quiet();
         gap_pct = gap_mix[p];
         stall_pct = stall_mix[p];
         goal = sb.pixels_seen + PHASE_ITEMS;
         while (sb.pixels_seen < goal) begin
            if ($urandom_range(99) < 20) begin
               // Sometimes leave a row open across the width change.
               if ($urandom_range(99) < 30) begin
                  part = $urandom_range(1, sb.used_width());
                  repeat (part) send_pixel(1'($urandom_range(1)), 1'b0);
               end
               write_width(pick_width());
            end
            random_frame();
         end
      end

      // Close any open frame, then drain.
      send_pixel(1'b1, 1'b1);
      wait_quiet();
      $display("Run covered %0d pixel transfers and %0d frame results,",
               sb.pixels_seen, sb.frames_checked);
      $display("with row widths from 0 to 255 and four handshake pressure mixes.");
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
